FILE: design/srlc_pkg.sv
`default_nettype none

package srlc_pkg;

  // Fixed-point widths: data Q16.16, coefficients Q8.24
  localparam int DataW   = 32;
  localparam int CoefW   = 32;
  localparam int ProdW   = DataW + CoefW;
  localparam int FracSh  = 24;
  localparam int RndW    = ProdW - FracSh;
  localparam int AccW    = RndW + 4;
  localparam int PcW     = 5;
  localparam int RegIdxW = 3;
  localparam int TermW   = 2;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [CoefW-1:0] coef_t;

  // Configuration register indexes
  localparam logic [RegIdxW-1:0] REG_A00  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_A01  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_A10  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_A11  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_B0   = 3'd4;
  localparam logic [RegIdxW-1:0] REG_B1   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_TERM = 3'd6;

  // Coefficient operand of the shared multiplier
  typedef enum logic [2:0] {
    CS_A00,
    CS_A01,
    CS_A10,
    CS_A11,
    CS_B0,
    CS_B1
  } coef_sel_e;

  // Data operand of the shared multiplier
  typedef enum logic [2:0] {
    OS_S0,
    OS_S1,
    OS_PREV,
    OS_V,
    OS_INI,
    OS_T0
  } opnd_sel_e;

  // Accumulator operation on the product registered one step earlier
  typedef enum logic [1:0] {
    AC_NONE,
    AC_LOAD,
    AC_ADD,
    AC_HIST
  } acc_op_e;

  // Write-back of the saturated accumulator, the branch voltage or the initial current
  typedef enum logic [2:0] {
    WB_NONE,
    WB_VOLT,
    WB_CUR,
    WB_T0,
    WB_STATE,
    WB_INIT,
    WB_HIST
  } wb_op_e;

  typedef struct packed {
    coef_sel_e coef;
    opnd_sel_e opnd;
    acc_op_e   acc;
    wb_op_e    wb;
    logic      br_init;
    logic      last;
  } cw_t;

  typedef struct packed {
    logic start;
    logic en;
    cw_t  cw;
  } ctrl_t;

  typedef struct packed {
    logic act_init;
  } status_t;

  // Entry of the init program
  localparam logic [PcW-1:0] PcInit = PcW'(16);

  function automatic cw_t mk_cw(input coef_sel_e coef, input opnd_sel_e opnd,
                                input acc_op_e acc, input wb_op_e wb,
                                input logic br_init, input logic last);
    cw_t w;
    w.coef    = coef;
    w.opnd    = opnd;
    w.acc     = acc;
    w.wb      = wb;
    w.br_init = br_init;
    w.last    = last;
    return w;
  endfunction

  // Control store: step program at 0, init program at PcInit
  function automatic cw_t ucode(input logic [PcW-1:0] pc);
    cw_t w;
    case (pc)
      // load branch voltage, branch to init program for init items
      5'd0:  w = mk_cw(CS_B1,  OS_V,    AC_NONE, WB_VOLT,  1'b1, 1'b0);
      // current = history + b1*v
      5'd1:  w = mk_cw(CS_B1,  OS_V,    AC_NONE, WB_NONE,  1'b0, 1'b0);
      5'd2:  w = mk_cw(CS_A00, OS_S0,   AC_HIST, WB_NONE,  1'b0, 1'b0);
      // new s0 row
      5'd3:  w = mk_cw(CS_A01, OS_S1,   AC_LOAD, WB_CUR,   1'b0, 1'b0);
      5'd4:  w = mk_cw(CS_B0,  OS_PREV, AC_ADD,  WB_NONE,  1'b0, 1'b0);
      5'd5:  w = mk_cw(CS_B0,  OS_V,    AC_ADD,  WB_NONE,  1'b0, 1'b0);
      5'd6:  w = mk_cw(CS_A10, OS_S0,   AC_ADD,  WB_NONE,  1'b0, 1'b0);
      // new s1 row
      5'd7:  w = mk_cw(CS_A11, OS_S1,   AC_LOAD, WB_T0,    1'b0, 1'b0);
      5'd8:  w = mk_cw(CS_B1,  OS_PREV, AC_ADD,  WB_NONE,  1'b0, 1'b0);
      5'd9:  w = mk_cw(CS_B1,  OS_V,    AC_ADD,  WB_NONE,  1'b0, 1'b0);
      5'd10: w = mk_cw(CS_A10, OS_T0,   AC_ADD,  WB_NONE,  1'b0, 1'b0);
      // commit state, history row
      5'd11: w = mk_cw(CS_A10, OS_T0,   AC_LOAD, WB_STATE, 1'b0, 1'b0);
      5'd12: w = mk_cw(CS_A11, OS_S1,   AC_NONE, WB_NONE,  1'b0, 1'b0);
      5'd13: w = mk_cw(CS_B1,  OS_V,    AC_ADD,  WB_NONE,  1'b0, 1'b0);
      5'd14: w = mk_cw(CS_B1,  OS_V,    AC_ADD,  WB_NONE,  1'b0, 1'b0);
      5'd15: w = mk_cw(CS_B1,  OS_V,    AC_NONE, WB_HIST,  1'b0, 1'b1);
      // init: s0 = a01*I + b0*v, s1 = I
      5'd16: w = mk_cw(CS_A01, OS_INI,  AC_NONE, WB_NONE,  1'b0, 1'b0);
      5'd17: w = mk_cw(CS_B0,  OS_V,    AC_LOAD, WB_NONE,  1'b0, 1'b0);
      5'd18: w = mk_cw(CS_B0,  OS_V,    AC_ADD,  WB_NONE,  1'b0, 1'b0);
      5'd19: w = mk_cw(CS_A10, OS_S0,   AC_NONE, WB_INIT,  1'b0, 1'b0);
      // init: history row
      5'd20: w = mk_cw(CS_A10, OS_S0,   AC_NONE, WB_NONE,  1'b0, 1'b0);
      5'd21: w = mk_cw(CS_A11, OS_S1,   AC_LOAD, WB_NONE,  1'b0, 1'b0);
      5'd22: w = mk_cw(CS_B1,  OS_V,    AC_ADD,  WB_NONE,  1'b0, 1'b0);
      5'd23: w = mk_cw(CS_B1,  OS_V,    AC_ADD,  WB_NONE,  1'b0, 1'b0);
      5'd24: w = mk_cw(CS_B1,  OS_V,    AC_NONE, WB_HIST,  1'b0, 1'b1);
      default: w = mk_cw(CS_B1, OS_V,   AC_NONE, WB_NONE,  1'b0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: design/srlc_if.sv
`default_nettype none

// Input item channel
interface srlc_in_if;
  import srlc_pkg::*;
  logic  valid;
  logic  ready;
  logic  action;
  data_t node0_voltage;
  data_t node1_voltage;
  data_t init_current;

  modport source (output valid, output action, output node0_voltage,
                  output node1_voltage, output init_current, input ready);
  modport sink   (input valid, input action, input node0_voltage,
                  input node1_voltage, input init_current, output ready);
endinterface

// Result item channel
interface srlc_out_if;
  import srlc_pkg::*;
  logic  valid;
  logic  ready;
  data_t branch_current;
  data_t history_current;
  logic  saturated;

  modport source (output valid, output branch_current, output history_current,
                  output saturated, input ready);
  modport sink   (input valid, input branch_current, input history_current,
                  input saturated, output ready);
endinterface

// Configuration write channel
interface srlc_cfg_if;
  import srlc_pkg::*;
  logic                valid;
  logic                ready;
  logic [RegIdxW-1:0]  index;
  logic [DataW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/srlc_seq.sv
`default_nettype none

module srlc_seq
  import srlc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    out_hold_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output ctrl_t   ctrl_o
);

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  cw_t            cw;
  logic           start;
  logic           en;

  // Fetch the control word of the current step
  assign cw    = ucode(pc_q);
  assign start = in_valid_i && !busy_q;
  // Stall only on the final step while the result register still holds an untaken result
  assign en    = busy_q && !(cw.last && out_hold_i);

  assign in_ready_o   = !busy_q;
  assign ctrl_o.start = start;
  assign ctrl_o.en    = en;
  assign ctrl_o.cw    = cw;

  // Advance the step counter, branch to the init program when asked
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (start) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end else if (en) begin
      if (cw.last) begin
        busy_d = 1'b0;
      end else if (cw.br_init && status_i.act_init) begin
        pc_d = PcInit;
      end else begin
        pc_d = pc_q + PcW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/srlc_dp.sv
`default_nettype none

module srlc_dp
  import srlc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  output status_t            status_o,
  // configuration write
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i,
  // input item payload
  input  logic               action_i,
  input  data_t              node0_voltage_i,
  input  data_t              node1_voltage_i,
  input  data_t              init_current_i,
  // result item
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output data_t              branch_current_o,
  output data_t              history_current_o,
  output logic               saturated_o
);

  localparam data_t DataMax = {1'b0, {(DataW-1){1'b1}}};
  localparam data_t DataMin = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [ProdW-1:0] RndHalf = ProdW'(1) <<< (FracSh - 1);

  cw_t cw;
  logic en;

  // Configuration registers
  coef_t a00_q, a01_q, a10_q, a11_q, b0_q, b1_q;
  logic [TermW-1:0] term_q;

  // Captured item
  logic  act_q;
  data_t n0_q, n1_q, ini_q;

  // Branch state and working registers
  data_t s0_q, s1_q, bv_q, prev_q, hist_q, t0_q, cur_q;
  logic  flag_q;

  // Shared multiplier and accumulator
  coef_t                    mc;
  data_t                    mo;
  logic signed [ProdW-1:0]  p_q;
  logic signed [ProdW-1:0]  p_rnd;
  logic signed [RndW-1:0]   rnd;
  logic signed [AccW-1:0]   acc_q;
  logic                     acc_clip;
  data_t                    acc_sat;

  // Branch voltage
  logic signed [DataW:0]    n1_ext, n0_ext, vw;
  logic                     v_clip;
  data_t                    v_sat;

  // Result register
  logic  out_valid_q;
  data_t out_cur_q, out_hist_q;
  logic  out_sat_q;

  assign cw = ctrl_i.cw;
  assign en = ctrl_i.en;
  assign status_o.act_init = !act_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a00_q  <= '0;
      a01_q  <= '0;
      a10_q  <= '0;
      a11_q  <= '0;
      b0_q   <= '0;
      b1_q   <= '0;
      term_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_A00:  a00_q  <= cfg_data_i;
        REG_A01:  a01_q  <= cfg_data_i;
        REG_A10:  a10_q  <= cfg_data_i;
        REG_A11:  a11_q  <= cfg_data_i;
        REG_B0:   b0_q   <= cfg_data_i;
        REG_B1:   b1_q   <= cfg_data_i;
        REG_TERM: term_q <= cfg_data_i[TermW-1:0];
        default:  ;
      endcase
    end
  end

  // Capture the item on acceptance
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      act_q <= action_i;
      n0_q  <= node0_voltage_i;
      n1_q  <= node1_voltage_i;
      ini_q <= init_current_i;
    end
  end

  // Branch voltage with grounding, saturated
  always_comb begin
    n1_ext = term_q[1] ? {n1_q[DataW-1], n1_q} : '0;
    n0_ext = term_q[0] ? {n0_q[DataW-1], n0_q} : '0;
    vw     = n1_ext - n0_ext;
    v_clip = vw[DataW] != vw[DataW-1];
    v_sat  = v_clip ? (vw[DataW] ? DataMin : DataMax) : vw[DataW-1:0];
  end

  // Select multiplier operands
  always_comb begin
    case (cw.coef)
      CS_A00:  mc = a00_q;
      CS_A01:  mc = a01_q;
      CS_A10:  mc = a10_q;
      CS_A11:  mc = a11_q;
      CS_B0:   mc = b0_q;
      CS_B1:   mc = b1_q;
      default: mc = '0;
    endcase
    case (cw.opnd)
      OS_S0:   mo = s0_q;
      OS_S1:   mo = s1_q;
      OS_PREV: mo = prev_q;
      OS_V:    mo = bv_q;
      OS_INI:  mo = ini_q;
      OS_T0:   mo = t0_q;
      default: mo = '0;
    endcase
  end

  // Register the exact product
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q <= ProdW'(mc) * ProdW'(mo);
    end
  end

  // Round half up to Q24.16
  assign p_rnd = p_q + RndHalf;
  assign rnd   = p_rnd[ProdW-1:FracSh];

  // Saturate the accumulator to 32 bits
  always_comb begin
    acc_clip = !((&acc_q[AccW-1:DataW-1]) || !(|acc_q[AccW-1:DataW-1]));
    acc_sat  = acc_clip ? (acc_q[AccW-1] ? DataMin : DataMax) : acc_q[DataW-1:0];
  end

  // Accumulate rounded products
  always_ff @(posedge clk_i) begin
    if (en) begin
      case (cw.acc)
        AC_LOAD: acc_q <= AccW'(rnd);
        AC_ADD:  acc_q <= acc_q + AccW'(rnd);
        AC_HIST: acc_q <= AccW'(hist_q) + AccW'(rnd);
        default: ;
      endcase
    end
  end

  // Write back working values
  always_ff @(posedge clk_i) begin
    if (en) begin
      case (cw.wb)
        WB_VOLT:  flag_q <= v_clip;
        WB_CUR: begin
          cur_q  <= acc_sat;
          flag_q <= flag_q | acc_clip;
        end
        WB_T0: begin
          t0_q   <= acc_sat;
          flag_q <= flag_q | acc_clip;
        end
        WB_INIT: begin
          cur_q  <= ini_q;
          flag_q <= flag_q | acc_clip;
        end
        WB_STATE: flag_q <= flag_q | acc_clip;
        WB_HIST:  flag_q <= flag_q | acc_clip;
        default:  ;
      endcase
    end
  end

  // Update branch state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q   <= '0;
      s1_q   <= '0;
      bv_q   <= '0;
      prev_q <= '0;
      hist_q <= '0;
    end else if (en) begin
      case (cw.wb)
        WB_VOLT: begin
          bv_q   <= v_sat;
          prev_q <= act_q ? bv_q : '0;
        end
        WB_STATE: begin
          s0_q <= t0_q;
          s1_q <= acc_sat;
        end
        WB_INIT: begin
          s0_q <= acc_sat;
          s1_q <= ini_q;
        end
        WB_HIST:  hist_q <= acc_sat;
        default:  ;
      endcase
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (en && cw.wb == WB_HIST) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && cw.wb == WB_HIST) begin
      out_cur_q  <= cur_q;
      out_hist_q <= acc_sat;
      out_sat_q  <= flag_q | acc_clip;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign branch_current_o  = out_cur_q;
  assign history_current_o = out_hist_q;
  assign saturated_o       = out_sat_q;

endmodule

`default_nettype wire

FILE: design/series_rlc_state_space_companion_top.sv
// A new item is accepted only once the previous one has finished; an init item runs the
// shorter init program. The single shared 32x32 multiplier is sequenced by the control
// store through every product, and the last step also waits while the previous result
// is still held. Reset: asynchronous, active low; clears coefficients to zero, terminal
// mask to 3 and the branch state; configuration writes are taken at any time.
`default_nettype none

module series_rlc_state_space_companion_top
  import srlc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  srlc_in_if.sink    in_i,
  srlc_out_if.source out_o,
  srlc_cfg_if.sink   cfg_i
);

  ctrl_t   ctrl;
  status_t status;
  logic    out_valid;
  logic    out_hold;

  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid;
  assign out_hold    = out_valid && !out_o.ready;

  // Step counter and control store
  srlc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_hold_i (out_hold),
    .status_i   (status),
    .in_ready_o (in_i.ready),
    .ctrl_o     (ctrl)
  );

  // Multiplier, accumulator, state and result register
  srlc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .status_o          (status),
    .cfg_we_i          (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .action_i          (in_i.action),
    .node0_voltage_i   (in_i.node0_voltage),
    .node1_voltage_i   (in_i.node1_voltage),
    .init_current_i    (in_i.init_current),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_valid),
    .branch_current_o  (out_o.branch_current),
    .history_current_o (out_o.history_current),
    .saturated_o       (out_o.saturated)
  );

endmodule

`default_nettype wire
